FILE: sv/stts_pkg.sv
// Shared types and codes of the sleep-timer task scheduler.
`timescale 1ns / 1ps
package stts_pkg;

  typedef enum logic [2:0] {
    OP_SPAWN    = 3'd0,
    OP_SLEEP    = 3'd1,
    OP_FINISH   = 3'd2,
    OP_TICK     = 3'd3,
    OP_DISPATCH = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STAT_DONE       = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_DISPATCHED = 3'd2,
    STAT_IDLE_WAIT  = 3'd3,
    STAT_NOTHING    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_READY    = 2'd1,
    SLOT_SLEEPING = 2'd2,
    SLOT_RUNNING  = 2'd3
  } slot_state_e;

  typedef struct packed {
    slot_state_e  state;
    logic [15:0]  left;
  } slot_t;

  localparam slot_t SLOT_RESET = '{state: SLOT_FREE, left: 16'd0};

  localparam logic [15:0] WAIT_CAP_RESET = 16'd1000;
  localparam logic [15:0] PERIOD_RESET   = 16'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAWN,
    S_CUR,
    S_TICK,
    S_DISP,
    S_EMIT
  } state_e;

endpackage

FILE: sv/stts_if.sv
// Valid/ready channel interfaces for scheduler operations and results.
`timescale 1ns / 1ps
interface stts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] sleep_ms;

  modport source (output valid, output op, output sleep_ms, input ready);
  modport sink   (input valid, input op, input sleep_ms, output ready);
endinterface

interface stts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  task_index;
  logic [15:0] wait_ms;

  modport source (output valid, output status, output task_index, output wait_ms, input ready);
  modport sink   (input valid, input status, input task_index, input wait_ms, output ready);
endinterface

FILE: sv/stts_slot_mem.sv
// Slot table memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
module stts_slot_mem #(
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output stts_pkg::slot_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  stts_pkg::slot_t wr_data_i
);
  import stts_pkg::*;

  slot_t            mem_q [DEPTH];
  slot_t            rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // An entry never written reads as a free slot with a zero countdown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : SLOT_RESET;

endmodule

FILE: sv/sleep_timer_task_scheduler.sv
// Top level of the sleep-timer task scheduler: sequencer around the slot table memory.
// Flow: an unknown op goes straight to the result; sleep, finish and dispatch read
// the running slot first; spawn and tick walk the table, and so does a dispatch scan.
// Throughput: one word at a time; the slot table memory is walked one entry per
// cycle through its single read port.
// Reset: asynchronous, active low; all slots read free (valid bits cleared at
// once, no clearing pass), period 1, wait cap 1000, running slot and scan position 0.
`timescale 1ns / 1ps
module sleep_timer_task_scheduler #(
  parameter int unsigned TASKS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  stts_in_if.sink     in_i,
  stts_out_if.source  out_o
);
  import stts_pkg::*;

  localparam int unsigned IW = $clog2(TASKS);
  localparam logic [IW-1:0] LAST = IW'(TASKS - 1);

  // Sequencer state and operation registers.
  state_e      state_q, state_d;
  op_e         op_q, op_d;
  logic [15:0] ms_q, ms_d;
  logic [IW-1:0] cnt_q, cnt_d;     // entries scanned so far
  logic [IW-1:0] addr_q, addr_d;   // entry whose read data arrives this cycle
  logic [15:0] best_q, best_d;     // smallest sleeping countdown seen
  logic        any_q, any_d;       // some slot sleeps

  // Architectural scheduler state outside the table.
  logic [IW-1:0] running_q, running_d;
  logic [IW-1:0] scanpos_q, scanpos_d;
  logic [15:0]   period_q, period_d;
  logic [15:0]   maxwait_q;

  // Pending result and output register.
  status_e     res_status_q, res_status_d;
  logic [IW-1:0] res_index_q, res_index_d;
  logic [15:0] res_wait_q, res_wait_d;
  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic [IW-1:0] out_index_q, out_index_d;
  logic [15:0] out_wait_q, out_wait_d;

  // Memory port.
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  slot_t         rd_data, wr_data;

  // Per-entry helpers.
  logic [15:0]   cap;
  logic [15:0]   v_floor;
  logic          sleeping;
  logic [15:0]   best_n;
  logic          any_n;
  logic [IW-1:0] addr_next;

  stts_slot_mem #(
    .DEPTH (TASKS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Treat a zero cap as one; raise a zero countdown to one for the idle wait.
  assign cap       = (maxwait_q == 16'd0) ? 16'd1 : maxwait_q;
  assign v_floor   = (rd_data.left == 16'd0) ? 16'd1 : rd_data.left;
  assign sleeping  = (rd_data.state == SLOT_SLEEPING);
  assign best_n    = (sleeping && (v_floor < best_q)) ? v_floor : best_q;
  assign any_n     = any_q | sleeping;
  assign addr_next = (addr_q == LAST) ? '0 : addr_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ms_d         = ms_q;
    cnt_d        = cnt_q;
    addr_d       = addr_q;
    best_d       = best_q;
    any_d        = any_q;
    running_d    = running_q;
    scanpos_d    = scanpos_q;
    period_d     = period_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_wait_d   = res_wait_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_wait_d   = out_wait_q;
    rd_en        = 1'b0;
    rd_addr      = addr_q;
    wr_en        = 1'b0;
    wr_addr      = addr_q;
    wr_data      = rd_data;
    in_i.ready   = 1'b0;

    // Drop the output word once taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d         = op_e'(in_i.op);
          ms_d         = in_i.sleep_ms;
          cnt_d        = '0;
          res_status_d = STAT_DONE;
          res_index_d  = '0;
          res_wait_d   = 16'd0;
          case (op_e'(in_i.op))
            OP_SPAWN, OP_TICK: begin
              rd_en   = 1'b1;
              rd_addr = '0;
              addr_d  = '0;
              state_d = (op_e'(in_i.op) == OP_SPAWN) ? S_SPAWN : S_TICK;
            end
            OP_SLEEP, OP_FINISH, OP_DISPATCH: begin
              rd_en   = 1'b1;
              rd_addr = running_q;
              addr_d  = running_q;
              state_d = S_CUR;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_SPAWN: begin
        // Take the lowest free slot; stop at the first hit.
        if (rd_data.state == SLOT_FREE) begin
          wr_en        = 1'b1;
          wr_data      = '{state: SLOT_READY, left: 16'd0};
          res_index_d  = addr_q;
          state_d      = S_EMIT;
        end else if (cnt_q == LAST) begin
          res_status_d = STAT_FULL;
          state_d      = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = addr_next;
          addr_d  = addr_next;
          cnt_d   = cnt_q + 1'b1;
        end
      end

      S_TICK: begin
        if (sleeping) begin
          wr_en = 1'b1;
          if (rd_data.left > period_q) begin
            wr_data = '{state: SLOT_SLEEPING, left: rd_data.left - period_q};
          end else begin
            wr_data = '{state: SLOT_READY, left: 16'd0};
          end
        end
        if (cnt_q == LAST) begin
          state_d = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = addr_next;
          addr_d  = addr_next;
          cnt_d   = cnt_q + 1'b1;
        end
      end

      S_CUR: begin
        // Entry of the running slot is here; sleep and finish without a running task do nothing, dispatch scans.
        case (op_q)
          OP_SLEEP: begin
            if (rd_data.state == SLOT_RUNNING) begin
              wr_en   = 1'b1;
              wr_data = '{state: SLOT_SLEEPING, left: ms_q};
            end
            state_d = S_EMIT;
          end
          OP_FINISH: begin
            if (rd_data.state == SLOT_RUNNING) begin
              wr_en   = 1'b1;
              wr_data = '{state: SLOT_FREE, left: rd_data.left};
            end
            state_d = S_EMIT;
          end
          default: begin
            if (rd_data.state == SLOT_RUNNING) begin
              res_status_d = STAT_DISPATCHED;
              res_index_d  = running_q;
              state_d      = S_EMIT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = scanpos_q;
              addr_d  = scanpos_q;
              cnt_d   = '0;
              best_d  = cap;
              any_d   = 1'b0;
              state_d = S_DISP;
            end
          end
        endcase
      end

      S_DISP: begin
        // Circular scan for a ready slot, tracking the smallest sleep on the way.
        if (rd_data.state == SLOT_READY) begin
          wr_en        = 1'b1;
          wr_data      = '{state: SLOT_RUNNING, left: rd_data.left};
          running_d    = addr_q;
          scanpos_d    = addr_next;
          res_status_d = STAT_DISPATCHED;
          res_index_d  = addr_q;
          state_d      = S_EMIT;
        end else if (cnt_q == LAST) begin
          if (any_n) begin
            period_d     = best_n;
            res_status_d = STAT_IDLE_WAIT;
            res_wait_d   = best_n;
          end else begin
            res_status_d = STAT_NOTHING;
          end
          state_d = S_EMIT;
        end else begin
          best_d  = best_n;
          any_d   = any_n;
          rd_en   = 1'b1;
          rd_addr = addr_next;
          addr_d  = addr_next;
          cnt_d   = cnt_q + 1'b1;
        end
      end

      S_EMIT: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
          out_wait_d   = res_wait_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      scanpos_q   <= '0;
      period_q    <= PERIOD_RESET;
      maxwait_q   <= WAIT_CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      scanpos_q   <= scanpos_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        maxwait_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ms_q         <= ms_d;
    cnt_q        <= cnt_d;
    addr_q       <= addr_d;
    best_q       <= best_d;
    any_q        <= any_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_wait_q   <= res_wait_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_wait_q   <= out_wait_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.task_index = 2'(out_index_q);
  assign out_o.wait_ms    = out_wait_q;

  // A scan never reads the entry it writes in the same cycle, so no forwarding.
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("slot table read and write hit the same entry");

  // The tick period is never zero.
  a_period_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q != 16'd0)
    else $error("tick period became zero");

  // Running slot and scan position stay inside the table.
  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running_q <= LAST) && (scanpos_q <= LAST))
    else $error("slot index out of range");

  // A dispatch with a running task reports it without a scan.
  a_dispatch_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CUR && op_q == OP_DISPATCH && rd_data.state == SLOT_RUNNING)
      |=> (state_q == S_EMIT && res_status_q == STAT_DISPATCHED))
    else $error("dispatch of a running task did not report it");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the sleep-timer task scheduler.
`timescale 1ns / 1ps
module tb_top;
  import stts_pkg::*;

  localparam int unsigned SLOTS         = 4;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 240;
  localparam int unsigned SETTLE_CYCLES = SLOTS + 4;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned MODE_SPAN     = 48;

  // Op codes past dispatch; the block must answer them with a plain done.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    status_e     status;
    logic [1:0]  task_index;
    logic [15:0] wait_ms;
  } sched_reply_t;

  // Shadow copy of the slot table; predicts one reply per accepted word.
  class task_table_tracker;
    slot_state_e  slot_state [SLOTS];
    logic [15:0]  countdown [SLOTS];
    logic [1:0]   running_slot;
    logic [1:0]   scan_pos;
    logic [15:0]  period_ms;
    logic [15:0]  wait_cap;
    sched_reply_t replies_due [$];
    int unsigned  mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] = SLOT_FREE;
        countdown[i]  = '0;
      end
      running_slot = '0;
      scan_pos     = '0;
      period_ms    = PERIOD_RESET;
      wait_cap     = WAIT_CAP_RESET;
      mismatches   = 0;
    endfunction

    function void set_wait_cap(logic [15:0] value);
      wait_cap = value;
    endfunction

    function void note_word(logic [2:0] op, logic [15:0] sleep_ms);
      sched_reply_t reply;
      bit           found;
      bit           any_sleeping;
      logic [1:0]   pos;
      logic [15:0]  best;
      logic [15:0]  v;
      reply = '{status: STAT_DONE, task_index: 2'd0, wait_ms: 16'd0};
      found = 1'b0;
      any_sleeping = 1'b0;
      case (op)
        OP_SPAWN: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_state[i] == SLOT_FREE) begin
              slot_state[i]    = SLOT_READY;
              countdown[i]     = '0;
              reply.task_index = i[1:0];
              found            = 1'b1;
            end
          end
          if (!found) reply.status = STAT_FULL;
        end
        OP_SLEEP: begin
          if (slot_state[running_slot] == SLOT_RUNNING) begin
            countdown[running_slot]  = sleep_ms;
            slot_state[running_slot] = SLOT_SLEEPING;
          end
        end
        OP_FINISH: begin
          if (slot_state[running_slot] == SLOT_RUNNING)
            slot_state[running_slot] = SLOT_FREE;
        end
        OP_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_state[i] == SLOT_SLEEPING) begin
              if (countdown[i] > period_ms) begin
                countdown[i] = countdown[i] - period_ms;
              end else begin
                countdown[i]  = '0;
                slot_state[i] = SLOT_READY;
              end
            end
          end
        end
        OP_DISPATCH: begin
          if (slot_state[running_slot] == SLOT_RUNNING) begin
            reply.status     = STAT_DISPATCHED;
            reply.task_index = running_slot;
          end else begin
            pos = scan_pos;
            for (int n = 0; n < SLOTS; n++) begin
              if (!found && slot_state[pos] == SLOT_READY) begin
                slot_state[pos]  = SLOT_RUNNING;
                running_slot     = pos;
                scan_pos         = pos + 2'd1;
                reply.status     = STAT_DISPATCHED;
                reply.task_index = pos;
                found            = 1'b1;
              end
              pos = pos + 2'd1;
            end
            if (!found) begin
              best = (wait_cap == 16'd0) ? 16'd1 : wait_cap;
              for (int i = 0; i < SLOTS; i++) begin
                if (slot_state[i] == SLOT_SLEEPING) begin
                  v = (countdown[i] == 16'd0) ? 16'd1 : countdown[i];
                  any_sleeping = 1'b1;
                  if (v < best) best = v;
                end
              end
              if (any_sleeping) begin
                period_ms     = best;
                reply.status  = STAT_IDLE_WAIT;
                reply.wait_ms = best;
              end else begin
                reply.status = STAT_NOTHING;
              end
            end
          end
        end
        default: ;
      endcase
      replies_due.push_back(reply);
    endfunction

    function void check_result(logic [2:0] status, logic [1:0] task_index,
                               logic [15:0] wait_ms);
      sched_reply_t want;
      if (replies_due.size() == 0) begin
        $error("result word with no word outstanding: status %0d", status);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (task_index !== want.task_index) begin
        $error("task_index: expected %0d, got %0d", want.task_index, task_index);
        mismatches++;
      end
      if (wait_ms !== want.wait_ms) begin
        $error("wait_ms: expected %0d, got %0d", want.wait_ms, wait_ms);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  stts_in_if  in_if ();
  stts_out_if out_if ();

  task_table_tracker board = new();

  // Burst modes: when set, that side never idles.
  bit          src_burst = 1'b0;
  bit          snk_burst = 1'b0;
  int unsigned next_gap  = 0;
  logic [15:0] phase_caps [PHASES];

  sleep_timer_task_scheduler #(.TASKS(SLOTS)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // Hold the input side quiet and known from time zero.
  initial begin
    in_if.valid    <= 1'b0;
    in_if.op       <= OP_SPAWN;
    in_if.sleep_ms <= '0;
  end

  // Sink: stall a random number of cycles before each result word,
  // switching between stalling and burst stretches now and then.
  always begin : result_sink
    int unsigned stall;
    int unsigned taken;
    if (taken % MODE_SPAN == 0) snk_burst = ($urandom_range(0, 3) == 0);
    stall = draw_gap(snk_burst);
    if (stall > 0) begin
      out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
    out_if.ready <= 1'b1;
    do @(posedge clk_i); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
    taken++;
  end

  // Check every result word on the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      board.check_result(out_if.status, out_if.task_index, out_if.wait_ms);
  end

  // Abort when neither channel moves a word for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL sleep_timer_task_scheduler");
    $finish;
  end

  // Present one word, wait for the handshake and note it for prediction.
  // Keep valid high when the next word follows without a gap, so valid
  // never drops and rises again within one step.
  task automatic send_word(input logic [2:0] op, input logic [15:0] sleep_ms);
    repeat (next_gap) @(posedge clk_i);
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.sleep_ms <= sleep_ms;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.note_word(op, sleep_ms);
    next_gap = draw_gap(src_burst);
    if (next_gap > 0) in_if.valid <= 1'b0;
  endtask

  // Drop valid, wait for every outstanding result, then let the
  // sequencer settle back to idle. A nonzero gap already dropped it.
  task automatic drain_results();
    if (next_gap == 0) in_if.valid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the wait cap; only called with the block drained.
  task automatic write_wait_cap(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_wait_cap(value);
  endtask

  // Weighted op draw: mostly dispatch, tick and sleep so that tasks
  // cycle through every slot state; a few reserved op codes as noise.
  task automatic send_random_word();
    int unsigned pick;
    int unsigned kind;
    logic [2:0]  op;
    logic [15:0] ms;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    if (pick < 14)      op = OP_SPAWN;
    else if (pick < 30) op = OP_SLEEP;
    else if (pick < 40) op = OP_FINISH;
    else if (pick < 58) op = OP_TICK;
    else if (pick < 96) op = OP_DISPATCH;
    else                op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    // Favor short sleeps so ticks wake tasks; keep some full-range ones.
    if (kind < 5)       ms = 16'($urandom_range(0, 12));
    else if (kind < 8)  ms = 16'($urandom_range(0, 3000));
    else if (kind == 8) ms = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else                ms = 16'($urandom);
    send_word(op, ms);
  endtask

  initial begin
    // Hold reset, then release it on a rising edge.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, calls with no running task, full table,
    // repeated dispatch, zero and maximum sleeps, idle waits, reserved ops.
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_SLEEP, 16'd5);
    send_word(OP_FINISH, 16'd0);
    repeat (SLOTS) send_word(OP_SPAWN, 16'd0);
    send_word(OP_SPAWN, 16'd0);
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_SLEEP, 16'd0);
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_SLEEP, 16'hFFFF);
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_FINISH, 16'd0);
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_SLEEP, 16'h5555);
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_TICK, 16'd0);
    send_word(OP_UNUSED_FIRST, 16'hFFFF);
    send_word(OP_UNUSED_FIRST + 3'd1, 16'd0);
    send_word(OP_UNUSED_LAST, 16'd0);
    send_word(OP_DISPATCH, 16'd0);
    send_word(OP_SLEEP, 16'hAAAA);
    send_word(OP_DISPATCH, 16'd0);

    // Walk the cap through its extremes, zero included, and a few
    // random settings; the table carries over from phase to phase.
    phase_caps = '{16'd0, 16'd1, 16'hFFFF, 16'd2, WAIT_CAP_RESET, 16'd7,
                   16'($urandom), 16'($urandom_range(1, 200))};
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_wait_cap(phase_caps[p]);
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (w % MODE_SPAN == 0) src_burst = ($urandom_range(0, 3) == 0);
        // Now and then pause until every result is back.
        if ($urandom_range(0, 149) == 0) drain_results();
        send_random_word();
      end
    end

    drain_results();
    if (board.mismatches == 0 && board.replies_due.size() == 0)
      $display("PASS sleep_timer_task_scheduler");
    else
      $display("FAIL sleep_timer_task_scheduler");
    $finish;
  end

endmodule

FILE: sim.f
sv/stts_pkg.sv
sv/stts_if.sv
sv/stts_slot_mem.sv
sv/sleep_timer_task_scheduler.sv
tb/sv/tb_top.sv
